@@ rtl/core/aavr_pkg.sv @@
// Package: constants, types and tables for the axis-angle vector rotator
`timescale 1ns / 1ps
package aavr_pkg;
	localparam int CordicStagesDefault = 16;
	localparam int AtanEntries = 24;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam int ZW = 34;
	localparam int XW = 34;
	localparam int QW = 17;
	localparam int MW = 36;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		case (idx)
			5'd0: r = 34'sd536870912;
			5'd1: r = 34'sd316933406;
			5'd2: r = 34'sd167458907;
			5'd3: r = 34'sd85004756;
			5'd4: r = 34'sd42667331;
			5'd5: r = 34'sd21354465;
			5'd6: r = 34'sd10679838;
			5'd7: r = 34'sd5340245;
			5'd8: r = 34'sd2670163;
			5'd9: r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} payload_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) r = 16'sh7fff;
		else if (v < -64'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction
endpackage

@@ rtl/core/aavr_cordic_cell.sv @@
// One CORDIC rotation cell with its own pipeline register and payload carry
`timescale 1ns / 1ps
module aavr_cordic_cell #(
	parameter int Shift = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  aavr_pkg::cordic_t c_in,
	input  aavr_pkg::payload_t p_in,
	output logic             vld_out,
	output aavr_pkg::cordic_t c_s1,
	output aavr_pkg::payload_t p_s1
);
	import aavr_pkg::*;
	localparam logic [4:0] Idx = 5'(Shift);
	logic signed [ZW-1:0] at;
	cordic_t nx;

	always_comb begin
		at = atan_lut(Idx);
		if (!c_in.z[ZW-1]) begin
			nx.x = c_in.x - (c_in.y >>> Shift);
			nx.y = c_in.y + (c_in.x >>> Shift);
			nx.z = c_in.z - at;
		end else begin
			nx.x = c_in.x + (c_in.y >>> Shift);
			nx.y = c_in.y - (c_in.x >>> Shift);
			nx.z = c_in.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= nx;
			p_s1 <= p_in;
		end
	end
endmodule

@@ rtl/core/aavr_matrix.sv @@
// Quaternion, rotation matrix and matrix-vector product pipeline
`timescale 1ns / 1ps
module aavr_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  aavr_pkg::cordic_t c_in,
	input  aavr_pkg::payload_t p_in,
	output logic              vld_out,
	output logic signed [15:0] rx,
	output logic signed [15:0] ry,
	output logic signed [15:0] rz
);
	import aavr_pkg::*;
	logic [5:0] vld_q;
	logic signed [QW-1:0] c_s1, s_s1, q0_s2, q1_s2, q2_s2, q3_s2;
	payload_t p_s1, p_s2, p_s3, p_s4;
	logic signed [33:0] q0q0_s3, q1q1_s3, q2q2_s3, q3q3_s3, q1q2_s3, q0q3_s3;
	logic signed [33:0] q1q3_s3, q0q2_s3, q2q3_s3, q0q1_s3;
	logic signed [MW-1:0] m_s4 [9];
	logic signed [63:0] t_s5 [9];
	logic signed [XW-1:0] cr, sr;
	logic signed [15:0] rx_s6, ry_s6, rz_s6;

	assign cr = c_in.x + 34'sd32768;
	assign sr = c_in.y + 34'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[4:0], vld_in};
	end
	assign vld_out = vld_q[5];

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= QW'(cr >>> 16);
			s_s1 <= QW'(sr >>> 16);
			p_s1 <= p_in;
			q0_s2 <= c_s1;
			q1_s2 <= QW'((34'(s_s1) * 34'(p_s1.ax) + 34'sd8192) >>> 14);
			q2_s2 <= QW'((34'(s_s1) * 34'(p_s1.ay) + 34'sd8192) >>> 14);
			q3_s2 <= QW'((34'(s_s1) * 34'(p_s1.az) + 34'sd8192) >>> 14);
			p_s2 <= p_s1;
			q0q0_s3 <= 34'(q0_s2) * 34'(q0_s2);
			q1q1_s3 <= 34'(q1_s2) * 34'(q1_s2);
			q2q2_s3 <= 34'(q2_s2) * 34'(q2_s2);
			q3q3_s3 <= 34'(q3_s2) * 34'(q3_s2);
			q1q2_s3 <= 34'(q1_s2) * 34'(q2_s2);
			q0q3_s3 <= 34'(q0_s2) * 34'(q3_s2);
			q1q3_s3 <= 34'(q1_s2) * 34'(q3_s2);
			q0q2_s3 <= 34'(q0_s2) * 34'(q2_s2);
			q2q3_s3 <= 34'(q2_s2) * 34'(q3_s2);
			q0q1_s3 <= 34'(q0_s2) * 34'(q1_s2);
			p_s3 <= p_s2;
			m_s4[0] <= MW'(q0q0_s3) + MW'(q1q1_s3) - MW'(q2q2_s3) - MW'(q3q3_s3);
			m_s4[1] <= (MW'(q1q2_s3) - MW'(q0q3_s3)) <<< 1;
			m_s4[2] <= (MW'(q1q3_s3) + MW'(q0q2_s3)) <<< 1;
			m_s4[3] <= (MW'(q1q2_s3) + MW'(q0q3_s3)) <<< 1;
			m_s4[4] <= MW'(q0q0_s3) - MW'(q1q1_s3) + MW'(q2q2_s3) - MW'(q3q3_s3);
			m_s4[5] <= (MW'(q2q3_s3) - MW'(q0q1_s3)) <<< 1;
			m_s4[6] <= (MW'(q1q3_s3) - MW'(q0q2_s3)) <<< 1;
			m_s4[7] <= (MW'(q2q3_s3) + MW'(q0q1_s3)) <<< 1;
			m_s4[8] <= MW'(q0q0_s3) - MW'(q1q1_s3) - MW'(q2q2_s3) + MW'(q3q3_s3);
			p_s4 <= p_s3;
			for (int r = 0; r < 3; r++) begin
				t_s5[3*r]   <= 64'(m_s4[3*r])   * 64'(p_s4.vx);
				t_s5[3*r+1] <= 64'(m_s4[3*r+1]) * 64'(p_s4.vy);
				t_s5[3*r+2] <= 64'(m_s4[3*r+2]) * 64'(p_s4.vz);
			end
		end
	end

	always_comb begin
		rx_s6 = sat16((t_s5[0] + t_s5[1] + t_s5[2] + 64'sd134217728) >>> 28);
		ry_s6 = sat16((t_s5[3] + t_s5[4] + t_s5[5] + 64'sd134217728) >>> 28);
		rz_s6 = sat16((t_s5[6] + t_s5[7] + t_s5[8] + 64'sd134217728) >>> 28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx <= rx_s6;
			ry <= ry_s6;
			rz <= rz_s6;
		end
	end
endmodule

@@ rtl/core/axis_angle_vector_rotation.sv @@
// Top level: axis-angle vector rotator, CORDIC cell chain plus matrix pipeline
//  channel | valid     | stall     | payload
//  in      | valid     | stall     | vec_x/y/z, axis_x/y/z, angle
//  out     | out_valid | out_stall | rot_x, rot_y, rot_z
// One transaction per cycle while the output is not stalled; registers: one per CORDIC cell,
// five for matrix and product stages, one output register.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
module axis_angle_vector_rotation #(
	parameter int CORDIC_STAGES = aavr_pkg::CordicStagesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic stall,
	input  logic signed [15:0] vec_x,
	input  logic signed [15:0] vec_y,
	input  logic signed [15:0] vec_z,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] rot_x,
	output logic signed [15:0] rot_y,
	output logic signed [15:0] rot_z
);
	import aavr_pkg::*;
	localparam int N = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
	logic en;
	logic vld_c [N+1];
	cordic_t cc [N+1];
	payload_t pc [N+1];

	// advance whenever the final register is free
	assign en = !(out_valid && out_stall);
	assign stall = !en;

	assign vld_c[0] = valid;
	assign cc[0].x = CordicGain;
	assign cc[0].y = '0;
	assign cc[0].z = {{3{angle[15]}}, angle, 15'b0};
	assign pc[0] = '{vx: vec_x, vy: vec_y, vz: vec_z, ax: axis_x, ay: axis_y, az: axis_z};

	for (genvar i = 0; i < N; i++) begin : g_cell
		aavr_cordic_cell #(.Shift(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[i]), .c_in(cc[i]), .p_in(pc[i]),
			.vld_out(vld_c[i+1]), .c_s1(cc[i+1]), .p_s1(pc[i+1])
		);
	end

	aavr_matrix u_mat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_c[N]), .c_in(cc[N]), .p_in(pc[N]),
		.vld_out(out_valid), .rx(rot_x), .ry(rot_y), .rz(rot_z)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y))
		else $error("result changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !stall)
		else $error("pipeline stalled while output empty");
endmodule
